@@ rtl/core/wrda_pkg.sv @@
// ----------------------------------------------------------------------------
// wrda_pkg
// Widths and constants for the wheel revolution distance accumulator.
// ----------------------------------------------------------------------------
package wrda_pkg;

   localparam int unsigned COUNT_W = 16;
   localparam int unsigned TOTAL_W = 32;
   localparam int unsigned CIRC_W  = 12;
   localparam int unsigned DIST_W  = TOTAL_W + CIRC_W;
   localparam int unsigned JUMP_W  = COUNT_W + CIRC_W;

   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [TOTAL_W-1:0] total_type;
   typedef logic [CIRC_W-1:0]  circ_type;
   typedef logic [DIST_W-1:0]  dist_type;

   localparam count_type          GUARD_LIMIT   = 16'd65450;
   localparam count_type          ROLL_SPAN     = 16'd65535;
   localparam logic [JUMP_W-1:0]  JUMP_LIMIT_MM = 28'd750;
   localparam circ_type           CIRC_RESET    = 12'd2096;
   localparam total_type          TOTAL_MAX     = 32'hFFFF_FFFF;

endpackage

@@ rtl/core/wheel_rev_distance_accumulator.sv @@
// ----------------------------------------------------------------------------
// wheel_rev_distance_accumulator
// Accumulates wheel revolutions from a 16-bit rolling sensor count and
// reports the saturating total and the distance travelled in millimetres.
// ----------------------------------------------------------------------------
// Pipeline: input register, total update, then the distance multiply into the
// result register.
// Throughput: one sample per cycle; each stage moves on as soon as the stage
// after it has room, so a stalled result blocks the input only once all full.
// Reset (synchronous): pipeline empty, total and last count zero,
// circumference 2096 mm.
module wheel_rev_distance_accumulator
   import wrda_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // sample channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [COUNT_W-1:0]  req_rev_count,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [TOTAL_W-1:0]  rsp_total_revs,
   output logic [DIST_W-1:0]   rsp_distance_mm,
   // circumference register
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CIRC_W-1:0]   csr_tire_circumference_mm
);

   circ_type  circ_ff;

   logic      s1_valid_ff;
   count_type s1_count_ff;

   logic      s2_valid_ff;
   count_type last_count_ff,    last_count_in;
   total_type running_total_ff, running_total_in;
   logic      saw_zero_ff,      saw_zero_in;

   logic      rsp_valid_ff;
   total_type rsp_total_ff;
   dist_type  rsp_dist_ff;

   logic en1, en2, en3;

   logic [TOTAL_W:0]  add_amount;
   logic [TOTAL_W:0]  sum;
   logic [JUMP_W-1:0] jump_mm;
   count_type         jump;

   assign en3 = !rsp_valid_ff || !rsp_stall;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;

   assign req_stall = !en1;
   assign csr_ready = 1'b1;

   // circumference register
   always_ff @(posedge clock) begin
      if (reset) begin
         circ_ff <= CIRC_RESET;
      end else if (csr_valid) begin
         circ_ff <= csr_tire_circumference_mm;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_valid) begin
         s1_count_ff <= req_rev_count;
      end
   end

   // total update
   assign jump    = last_count_ff - s1_count_ff;
   assign jump_mm = JUMP_W'(jump) * JUMP_W'(circ_ff);

   always_comb begin
      add_amount = '0;
      if (s1_count_ff > last_count_ff) begin
         add_amount = (TOTAL_W+1)'(s1_count_ff - last_count_ff);
      end else if (s1_count_ff < last_count_ff) begin
         if (saw_zero_ff && (last_count_ff < GUARD_LIMIT)) begin
            // implausible jump after a missing reading doubles the total
            if (jump_mm > JUMP_LIMIT_MM) begin
               add_amount = {1'b0, running_total_ff};
            end else begin
               add_amount = (TOTAL_W+1)'(s1_count_ff);
            end
         end else begin
            add_amount = (TOTAL_W+1)'(s1_count_ff) + (TOTAL_W+1)'(ROLL_SPAN - last_count_ff);
         end
      end
   end

   assign sum = {1'b0, running_total_ff} + add_amount;

   always_comb begin
      last_count_in    = last_count_ff;
      running_total_in = running_total_ff;
      saw_zero_in      = saw_zero_ff;
      if (s1_count_ff == '0) begin
         saw_zero_in = 1'b1;
      end else begin
         if (last_count_ff != '0) begin
            running_total_in = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
         end
         last_count_in = s1_count_ff;
         saw_zero_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff      <= 1'b0;
         last_count_ff    <= '0;
         running_total_ff <= '0;
         saw_zero_ff      <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            last_count_ff    <= last_count_in;
            running_total_ff <= running_total_in;
            saw_zero_ff      <= saw_zero_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && s2_valid_ff) begin
         rsp_total_ff <= running_total_ff;
         rsp_dist_ff  <= DIST_W'(running_total_ff) * DIST_W'(circ_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_total_revs  = rsp_total_ff;
   assign rsp_distance_mm = rsp_dist_ff;

   // checks
   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> running_total_ff >= $past(running_total_ff))
      else $error("running total decreased");

   a_last_count_sticky: assert property (@(posedge clock) disable iff (reset)
      last_count_ff != '0 |=> last_count_ff != '0)
      else $error("last count returned to zero");

   a_zero_keeps_count: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && en2 && s1_count_ff == '0 |=>
         $stable(last_count_ff) && $stable(running_total_ff) && saw_zero_ff)
      else $error("zero sample changed the count or total");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted sample not held in input register");

endmodule

@@ tb/sv/wrda_checker.sv @@
// ----------------------------------------------------------------------------
// wrda_checker
// Watches the sample, result and circumference channels of the wheel
// revolution distance accumulator. It keeps its own odometer state, works
// out the total and distance for every accepted sample, and compares each
// result transfer, field by field, with the oldest reading still due.
// ----------------------------------------------------------------------------
module wrda_checker
   import wrda_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  count_type  req_rev_count,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  total_type  rsp_total_revs,
   input  dist_type   rsp_distance_mm,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  circ_type   csr_tire_circumference_mm,
   output int         mismatch_count,
   output int         results_due
);

   localparam count_type   GUARD_COUNT  = 16'd65450;
   localparam logic [16:0] WRAP_SPAN    = 17'd65535;
   localparam logic [27:0] JUMP_LIMIT   = 28'd750;
   localparam circ_type    CIRC_DEFAULT = 12'd2096;
   localparam total_type   TOTAL_CEIL   = 32'hFFFF_FFFF;

   typedef struct packed {
      total_type total_revs;
      dist_type  distance_mm;
   } odo_reading_type;

   odo_reading_type readings_due[$];

   circ_type  circ_mm    = CIRC_DEFAULT;
   count_type last_count = '0;
   total_type total      = '0;
   logic      missed     = 1'b0;
   int        errors     = 0;

   function automatic total_type clamp_add(total_type base, logic [32:0] amount);
      logic [33:0] sum;
      sum = {2'b00, base} + {1'b0, amount};
      return (sum > {2'b00, TOTAL_CEIL}) ? TOTAL_CEIL : sum[31:0];
   endfunction

   // Updates the odometer state with one sample and returns the reading it gives.
   function automatic odo_reading_type advance_odometer(count_type rev);
      logic [27:0]     jump_mm;
      odo_reading_type reading;
      if (rev != '0) begin
         if (last_count != '0) begin
            if (rev > last_count) begin
               total = clamp_add(total, {17'b0, count_type'(rev - last_count)});
            end else if (rev < last_count) begin
               // backwards step straight after a missing reading: suspect count
               if (missed && last_count < GUARD_COUNT) begin
                  jump_mm = {12'b0, count_type'(last_count - rev)} * {16'b0, circ_mm};
                  if (jump_mm > JUMP_LIMIT)
                     total = clamp_add(total, {1'b0, total});
                  else
                     total = clamp_add(total, {17'b0, rev});
               end else begin
                  total = clamp_add(total, {17'b0, rev} + WRAP_SPAN - {17'b0, last_count});
               end
            end
         end
         last_count = rev;
         missed     = 1'b0;
      end else begin
         missed = 1'b1;
      end
      reading.total_revs  = total;
      reading.distance_mm = {12'b0, total} * {32'b0, circ_mm};
      return reading;
   endfunction

   always @(posedge clock) begin
      odo_reading_type due;
      if (reset) begin
         readings_due.delete();
         circ_mm    = CIRC_DEFAULT;
         last_count = '0;
         total      = '0;
         missed     = 1'b0;
      end else begin
         // pop before push: a result never belongs to a sample of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (readings_due.size() == 0) begin
               errors++;
               $error("result transfer with nothing due: total_revs %0d, distance_mm %0d",
                      rsp_total_revs, rsp_distance_mm);
            end else begin
               due = readings_due.pop_front();
               if (rsp_total_revs !== due.total_revs) begin
                  errors++;
                  $error("total_revs: expected %0d, got %0d",
                         due.total_revs, rsp_total_revs);
               end
               if (rsp_distance_mm !== due.distance_mm) begin
                  errors++;
                  $error("distance_mm: expected %0d, got %0d",
                         due.distance_mm, rsp_distance_mm);
               end
            end
         end
         if (csr_valid && csr_ready)
            circ_mm = csr_tire_circumference_mm;
         if (req_valid && !req_stall)
            readings_due.push_back(advance_odometer(req_rev_count));
      end
      mismatch_count <= errors;
      results_due    <= readings_due.size();
   end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives samples and circumference writes into the wheel revolution distance
// accumulator: a directed opening over the rollover, guard and jump cases,
// then random phases at several circumferences, ending in saturation.
// ----------------------------------------------------------------------------
module testbench
   import wrda_pkg::*;
();

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_type;

   localparam count_type GUARD_COUNT = 16'd65450;

   logic      clock           = 1'b0;
   logic      reset           = 1'b1;
   logic      req_valid       = 1'b0;
   logic      req_stall;
   count_type req_rev_count   = '0;
   logic      rsp_valid;
   logic      rsp_stall       = 1'b0;
   total_type rsp_total_revs;
   dist_type  rsp_distance_mm;
   logic      csr_valid       = 1'b0;
   logic      csr_ready;
   circ_type  csr_circ        = '0;

   int mismatch_count;
   int results_due;

   int             burst_left = 0;
   count_type      last_sent  = '0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_left = 0;

   // zero with nothing seen, first count, equal, rise, rollovers with and
   // without a missing reading, guard limit either side
   count_type opening_seq [19] = '{16'd0, 16'd1, 16'd1, 16'd100, 16'd65535, 16'd5,
                                   16'd0, 16'd3, 16'd0, 16'd65500, 16'd65460, 16'd0,
                                   16'd10, 16'd65449, 16'd0, 16'd65448, 16'd65450,
                                   16'd0, 16'd1};
   // at 750 mm a one-count jump is on the limit, two counts go over it
   count_type boundary_seq [5] = '{16'd1000, 16'd0, 16'd999, 16'd0, 16'd997};

   wheel_rev_distance_accumulator DUT (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_rev_count             (req_rev_count),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_total_revs            (rsp_total_revs),
      .rsp_distance_mm           (rsp_distance_mm),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_tire_circumference_mm (csr_circ)
   );

   wrda_checker odo_check (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_rev_count             (req_rev_count),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_total_revs            (rsp_total_revs),
      .rsp_distance_mm           (rsp_distance_mm),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_tire_circumference_mm (csr_circ),
      .mismatch_count            (mismatch_count),
      .results_due               (results_due)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_left = $urandom_range(8, 60);
      end
      stall_left--;
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         default:     rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic send_rev(input count_type rev);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid     <= 1'b1;
      req_rev_count <= rev;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (rev != '0)
         last_sent = rev;
   endtask

   // only between phases, with every reading back and the pipe drained
   task automatic write_circumference(input circ_type mm);
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_circ  <= mm;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // pair_pct: share of missing-reading-then-lower-count pairs
   task automatic run_random(input int items, input int pair_pct, input int max_jump);
      int kind;
      int n;
      int span;
      n = 0;
      while (n < items) begin
         kind = $urandom_range(0, 99);
         if (kind < pair_pct && last_sent > 1 && last_sent < GUARD_COUNT) begin
            span = (max_jump < last_sent - 1) ? max_jump : last_sent - 1;
            send_rev('0);
            send_rev(last_sent - count_type'($urandom_range(1, span)));
            n += 2;
         end else begin
            if (kind < pair_pct + 6)
               send_rev('0);
            else if (kind < pair_pct + 11)
               send_rev(last_sent);
            else if (kind < pair_pct + 21)
               send_rev(count_type'($urandom()));
            else if (kind < pair_pct + 29)
               send_rev(count_type'($urandom_range(65440, 65535)));
            else
               send_rev(last_sent + count_type'($urandom_range(1, 1500)));
            n++;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_seq[i])
         send_rev(opening_seq[i]);
      write_circumference(12'd750);
      foreach (boundary_seq[i])
         send_rev(boundary_seq[i]);
      run_random(500, 1, 3);
      write_circumference('0);
      run_random(500, 3, 200);
      write_circumference(circ_type'($urandom_range(1, 4094)));
      run_random(500, 0, 1);
      // frequent doubling drives the total into saturation
      write_circumference('1);
      run_random(500, 25, 4000);
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_due == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
